// File: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding-window median filter
// Holds the field widths, the reset window length and the structs that pass
// between the top level and the sorted cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int DATA_W          = 32;
  localparam int WS_W            = 7;
  localparam int MAX_WINDOW_DEF  = 64;
  localparam logic [WS_W-1:0] WS_RESET = 7'd3;

  // Per-cell compare flags, seen by both neighbors.
  typedef struct packed {
    logic le_new;   // stored value <= incoming sample (and cell in use)
    logic lt_old;   // stored value <  evicted sample  (and cell in use)
  } swm_flags_t;

  // Broadcast control for one update of the cell row.
  typedef struct packed {
    logic upd;        // cells load their next value this cycle
    logic fill_mode;  // window not yet full: pure insertion
    logic path_low;   // window full and evicted value <= incoming sample
  } swm_ctrl_t;

endpackage

// File: src/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top: running lower-median filter over signed samples
// Keeps the last k samples in arrival order in a memory and as sorted cells;
// from the sample that fills the window on, each yields the lower median.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                  | Payload
//  --------+------------------------+-------------------------------------
//  input   | in_tvalid / in_tready  | tdata[31:0] sample, tuser restart
//  output  | out_tvalid / out_tready| tdata[31:0] median
//  config  | cfg_we                 | cfg_wdata[6:0] window_size
//
// Each sample passes through these steps in order: the evicted sample is
// read from the arrival-order memory, the whole cell row removes it and
// inserts the new sample, and the median cell is picked into the output
// register. The registered memory read and one row update per sample set these.
// A stalled output only holds the block in its last step; the next sample
// is taken as soon as the median sits in the output register.
// Reset is synchronous and needs no clearing pass: the fill count keeps
// unwritten entries from ever being used.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [swm_pkg::DATA_W-1:0]  in_tdata,   // [31:0] sample
  input  logic                        in_tuser,   // [0] restart
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swm_pkg::DATA_W-1:0]  out_tdata,  // [31:0] median
  input  logic                        cfg_we,
  input  logic [swm_pkg::WS_W-1:0]    cfg_wdata
);

  // KW holds a window length up to MAX_WINDOW; SW indexes a slot.
  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DW = swm_pkg::DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [swm_pkg::WS_W-1:0] ws_r, ws_nxt;
  logic [KW-1:0]            fill_r, fill_nxt;
  logic [SW-1:0]            oldest_r, oldest_nxt;
  logic                     emit_r, emit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DW-1:0]            out_data_r, out_data_nxt;
  logic [DW-1:0]            sample_r, sample_nxt;
  logic                     restart_r, restart_nxt;

  logic [KW-1:0]            win_len;
  logic [KW-1:0]            med_pos;
  logic [SW-1:0]            slot;
  logic [KW-1:0]            slot_inc;
  logic [KW-1:0]            fill_eff;
  logic                     full;
  logic [KW-1:0]            count;
  logic [DW-1:0]            evicted;
  swm_pkg::swm_ctrl_t       ctrl;
  logic                     ram_we;
  logic [SW-1:0]            ram_waddr;

  logic [DW-1:0]            cell_val   [MAX_WINDOW];
  swm_pkg::swm_flags_t      cell_flags [MAX_WINDOW];

  // Effective window length: zero acts as one, anything above the row
  // length acts as the row length.
  always_comb begin
    if (ws_r == '0) begin
      win_len = KW'(1);
    end else if (32'(ws_r) > MAX_WINDOW) begin
      win_len = KW'(MAX_WINDOW);
    end else begin
      win_len = KW'(ws_r);
    end
  end

  assign med_pos = (win_len - KW'(1)) >> 1;

  // The oldest slot wraps if the window was shortened.
  assign slot     = (KW'(oldest_r) >= win_len) ? '0 : oldest_r;
  assign slot_inc = KW'(slot) + KW'(1);

  // History as seen by the item in flight; restart empties it first.
  assign fill_eff = restart_r ? '0 : fill_r;
  assign full     = (fill_eff >= win_len);
  assign count    = full ? win_len : fill_eff;

  assign ctrl.upd       = (state_r == ST_UPD);
  assign ctrl.fill_mode = !full;
  assign ctrl.path_low  = full && ($signed(evicted) <= $signed(sample_r));

  // Arrival-order store: read the slot to be evicted when the sample is
  // taken, write the new sample during the cell update.
  assign ram_we    = (state_r == ST_UPD);
  assign ram_waddr = full ? slot : fill_eff[SW-1:0];

  swm_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WINDOW)
  ) u_age_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_r),
    .raddr (slot),
    .rdata (evicted)
  );

  // Sorted row: each cell talks only to its two neighbors. The bottom
  // neighbor of cell zero reads as "smaller than everything", the top
  // neighbor of the last cell as unused.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [DW-1:0]       below_val;
    logic [DW-1:0]       above_val;
    swm_pkg::swm_flags_t below_flags;
    swm_pkg::swm_flags_t above_flags;

    if (i == 0) begin : g_bot
      assign below_val   = '0;
      assign below_flags = '1;
    end else begin : g_mid_bot
      assign below_val   = cell_val[i-1];
      assign below_flags = cell_flags[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign above_val   = '0;
      assign above_flags = '0;
    end else begin : g_mid_top
      assign above_val   = cell_val[i+1];
      assign above_flags = cell_flags[i+1];
    end

    swm_cell #(
      .IDX (i),
      .KW  (KW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .sample      (sample_r),
      .oldest      (evicted),
      .below_val   (below_val),
      .below_flags (below_flags),
      .above_val   (above_val),
      .above_flags (above_flags),
      .val         (cell_val[i]),
      .flags       (cell_flags[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    ws_nxt        = ws_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sample_nxt    = sample_r;
    restart_nxt   = restart_r;

    // A transfer on the output frees the register.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt  = in_tdata;
          restart_nxt = in_tuser;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        if (full) begin
          oldest_nxt = (slot_inc >= win_len) ? '0 : slot_inc[SW-1:0];
          emit_nxt   = 1'b1;
        end else begin
          fill_nxt   = fill_eff + KW'(1);
          oldest_nxt = '0;
          emit_nxt   = (fill_eff + KW'(1) == win_len);
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!emit_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cell_val[med_pos[SW-1:0]];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new window length starts a fresh history.
    if (cfg_we) begin
      ws_nxt     = cfg_wdata;
      fill_nxt   = '0;
      oldest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= swm_pkg::WS_RESET;
      fill_r      <= '0;
      oldest_r    <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sample_r   <= sample_nxt;
    restart_r  <= restart_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: generic single-write, single-read memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one position of the sorted window
// Holds one sample; on an update it keeps its value, takes a neighbor's
// value or takes the incoming sample, decided from its own and its
// neighbors' compare flags, the broadcast control and, while filling, its index.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int IDX = 0,
  parameter int KW  = 7
) (
  input  logic                        clk,
  input  swm_pkg::swm_ctrl_t          ctrl,
  input  logic [KW-1:0]               count,
  input  logic [swm_pkg::DATA_W-1:0]  sample,
  input  logic [swm_pkg::DATA_W-1:0]  oldest,
  input  logic [swm_pkg::DATA_W-1:0]  below_val,
  input  swm_pkg::swm_flags_t         below_flags,
  input  logic [swm_pkg::DATA_W-1:0]  above_val,
  input  swm_pkg::swm_flags_t         above_flags,
  output logic [swm_pkg::DATA_W-1:0]  val,
  output swm_pkg::swm_flags_t         flags
);

  logic [swm_pkg::DATA_W-1:0] val_r;
  logic [swm_pkg::DATA_W-1:0] val_nxt;
  logic                       in_use;

  assign in_use       = KW'(IDX) < count;
  assign flags.le_new = in_use && ($signed(val_r) <= $signed(sample));
  assign flags.lt_old = in_use && ($signed(val_r) <  $signed(oldest));

  always_comb begin
    val_nxt = val_r;
    if (ctrl.path_low) begin
      // Evicted entry sits at or below the insertion point: upper part
      // slides down by one, the sample lands just under the first larger value.
      if (flags.lt_old) begin
        val_nxt = val_r;
      end else if (above_flags.le_new) begin
        val_nxt = above_val;
      end else if (flags.le_new) begin
        val_nxt = sample;
      end
    end else begin
      // Insertion point below the evicted entry (or plain insertion while
      // filling, where every used cell counts as below the hole).
      if (flags.le_new) begin
        val_nxt = val_r;
      end else if (below_flags.le_new) begin
        val_nxt = sample;
      end else if (ctrl.fill_mode ? (KW'(IDX) <= count) : below_flags.lt_old) begin
        val_nxt = below_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// File: src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks of the sliding-window median filter
// Watches the ports of the top level over time; attached by a bind.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [swm_pkg::DATA_W-1:0]  out_tdata
);

  // A held result stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output result changed or vanished while stalled");

  // After a sample is taken the block is busy through its update and output steps.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input accepted while a sample was still in work");

  // A fresh result only ever appears at the output step of a sample transfer.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("result appeared without a matching input transfer");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
